[sv/rcba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcba_pkg
// Shared widths, register indexes and types for the resonant controller.
// ----------------------------------------------------------------------------
package rcba_pkg;

    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_COEF_FRAC_BITS = 24;

    localparam int COEF_W    = 32;
    localparam int RAW_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_B0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd6;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coef_set;

endpackage

[sv/rcba_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcba_cfg_regs
// Coefficient and limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module rcba_cfg_regs #(
    parameter int SAMPLE_WIDTH = rcba_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rcba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcba_pkg::CFG_W-1:0]          i_cfg_data,
    output rcba_pkg::t_coef_set                 o_coefs,
    output logic signed [SAMPLE_WIDTH-1:0]      o_upper,
    output logic signed [SAMPLE_WIDTH-1:0]      o_lower
);

    localparam logic signed [SAMPLE_WIDTH-1:0] LIM_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] LIM_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    rcba_pkg::t_coef_set              r_coefs;
    logic signed [SAMPLE_WIDTH-1:0]   r_upper;
    logic signed [SAMPLE_WIDTH-1:0]   r_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
            r_upper <= LIM_MAX;
            r_lower <= LIM_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rcba_pkg::CFG_B0:    r_coefs.b0 <= i_cfg_data;
                rcba_pkg::CFG_B1:    r_coefs.b1 <= i_cfg_data;
                rcba_pkg::CFG_B2:    r_coefs.b2 <= i_cfg_data;
                rcba_pkg::CFG_A1:    r_coefs.a1 <= i_cfg_data;
                rcba_pkg::CFG_A2:    r_coefs.a2 <= i_cfg_data;
                rcba_pkg::CFG_UPPER: r_upper    <= i_cfg_data[SAMPLE_WIDTH-1:0];
                rcba_pkg::CFG_LOWER: r_lower    <= i_cfg_data[SAMPLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;
    assign o_upper = r_upper;
    assign o_lower = r_lower;

endmodule

[sv/rcba_biquad.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcba_biquad
// Direct-form-I biquad with rounding, 32-bit saturation, clamp and
// conditional history update (anti-windup).
// ----------------------------------------------------------------------------
module rcba_biquad #(
    parameter int SAMPLE_WIDTH   = rcba_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = rcba_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_reference,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_actual,
    input  rcba_pkg::t_coef_set                  i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_upper,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_lower,
    output logic signed [SAMPLE_WIDTH-1:0]       o_drive,
    output logic signed [rcba_pkg::RAW_W-1:0]    o_raw_drive,
    output logic                                 o_saturated
);

    localparam int EW    = SAMPLE_WIDTH + 1;
    localparam int PW    = rcba_pkg::COEF_W + EW;
    localparam int ACC_W = PW + 3;
    localparam int RW    = rcba_pkg::RAW_W;

    localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [RW-1:0]    RAW_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic signed [RW-1:0]    RAW_MIN = {1'b1, {(RW-1){1'b0}}};

    logic signed [EW-1:0]           r_e1, r_e2;
    logic signed [SAMPLE_WIDTH-1:0] r_u1, r_u2;

    logic signed [EW-1:0]    w_e0;
    logic signed [PW-1:0]    w_p_b0, w_p_b1, w_p_b2, w_p_a1, w_p_a2;
    logic signed [ACC_W-1:0] w_acc, w_shifted;
    logic signed [RW-1:0]    w_raw, w_upper, w_lower, w_clamped;
    logic                    w_above, w_below, w_hold;

    always_comb begin
        w_e0   = EW'(i_reference) - EW'(i_actual);
        w_p_b0 = i_coefs.b0 * w_e0;
        w_p_b1 = i_coefs.b1 * r_e1;
        w_p_b2 = i_coefs.b2 * r_e2;
        w_p_a1 = i_coefs.a1 * PW'(r_u1);
        w_p_a2 = i_coefs.a2 * PW'(r_u2);
        w_acc  = ACC_W'(w_p_b0) + ACC_W'(w_p_b1) + ACC_W'(w_p_b2)
               - ACC_W'(w_p_a1) - ACC_W'(w_p_a2) + ROUND_K;
        w_shifted = w_acc >>> COEF_FRAC_BITS;

        if (w_shifted > ACC_W'(RAW_MAX)) begin
            w_raw = RAW_MAX;
        end else if (w_shifted < ACC_W'(RAW_MIN)) begin
            w_raw = RAW_MIN;
        end else begin
            w_raw = w_shifted[RW-1:0];
        end

        w_upper = RW'(i_upper);
        w_lower = RW'(i_lower);
        w_above = w_raw > w_upper;
        w_below = w_raw < w_lower;

        if (w_above) begin
            w_clamped = w_upper;
        end else if (w_below) begin
            w_clamped = w_lower;
        end else begin
            w_clamped = w_raw;
        end

        w_hold = (w_above && !w_e0[EW-1] && (w_e0 != '0)) || (w_below && w_e0[EW-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1 <= '0;
            r_e2 <= '0;
            r_u1 <= '0;
            r_u2 <= '0;
        end else if (i_en && !w_hold) begin
            r_e2 <= r_e1;
            r_e1 <= w_e0;
            r_u2 <= r_u1;
            r_u1 <= w_clamped[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_drive     = w_clamped[SAMPLE_WIDTH-1:0];
    assign o_raw_drive = w_raw;
    assign o_saturated = (w_clamped != w_raw);

endmodule

[sv/resonant_controller_biquad_antiwindup_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resonant_controller_biquad_antiwindup_unit
// Proportional-resonant controller: biquad on the control error with output
// clamp and anti-windup, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Pipeline: input register, then biquad and clamp into the result register.
// Throughput: 1 transaction per cycle unless a low i_out_ready holds the
//   result register; the history registers close the loop around the
//   combinational biquad.
// Reset: synchronous active low; clears histories and valids, coefficients
//   to zero, limits to the full sample range.
module resonant_controller_biquad_antiwindup_unit #(
    parameter int SAMPLE_WIDTH   = rcba_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = rcba_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rcba_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rcba_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_reference,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_actual,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       o_drive,
    output logic signed [rcba_pkg::RAW_W-1:0]    o_raw_drive,
    output logic                                 o_saturated
);

    rcba_pkg::t_coef_set              w_coefs;
    logic signed [SAMPLE_WIDTH-1:0]   w_upper, w_lower;
    logic signed [SAMPLE_WIDTH-1:0]   w_drive;
    logic signed [rcba_pkg::RAW_W-1:0] w_raw_drive;
    logic                             w_saturated;
    logic                             w_fire;

    logic                             r_in_valid, n_in_valid;
    logic signed [SAMPLE_WIDTH-1:0]   r_reference, r_actual;
    logic                             r_out_valid, n_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]   r_drive;
    logic signed [rcba_pkg::RAW_W-1:0] r_raw_drive;
    logic                             r_saturated;

    rcba_cfg_regs #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (w_coefs),
        .o_upper     (w_upper),
        .o_lower     (w_lower)
    );

    rcba_biquad #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_biquad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_fire),
        .i_reference (r_reference),
        .i_actual    (r_actual),
        .i_coefs     (w_coefs),
        .i_upper     (w_upper),
        .i_lower     (w_lower),
        .o_drive     (w_drive),
        .o_raw_drive (w_raw_drive),
        .o_saturated (w_saturated)
    );

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_comb begin
        n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !w_fire);
        n_out_valid = w_fire || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_reference <= i_reference;
            r_actual    <= i_actual;
        end
        if (w_fire) begin
            r_drive     <= w_drive;
            r_raw_drive <= w_raw_drive;
            r_saturated <= w_saturated;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_raw_drive = r_raw_drive;
    assign o_saturated = r_saturated;

`ifndef SYNTH
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input not ready with empty result register");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid)
        else $error("pending sample dropped");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> (o_drive == w_upper || o_drive == w_lower))
        else $error("saturated drive not at a limit");

    a_unsat_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_saturated |-> o_raw_drive == rcba_pkg::RAW_W'(o_drive))
        else $error("unsaturated drive differs from raw");
`endif

endmodule
